// ===== src/ofrq_pkg.sv =====
// Shared types and constants for the oldest-first removal queue.
package ofrq_pkg;

  localparam int AGE_W  = 8;
  localparam int TAG_W  = 16;
  localparam int OCC_W  = 5;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

endpackage

// ===== src/ofrq_mem.sv =====
// Entry store: one write port, one read port, registered read data.
module ofrq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/oldest_first_removal_queue.sv =====
// Top level of the oldest-first removal queue: control, scan and gap-closing sequencer.
// A bounded queue of up to CAPACITY entries (8-bit age, person tag) kept in
// insertion order in one single-ported-read memory. An insert (tuser = 0) is
// written at the tail in the transfer cycle; its result then goes through the
// response state to the output register. A remove (tuser = 1) reads every
// held entry through the memory read port, one per cycle, keeping the greatest
// age and the earliest entry on a tie, then closes the gap by copying each
// later entry down one slot, one per cycle, then presents its result. A
// remove on an empty queue returns status "empty"; an insert on a full queue
// returns "full" and drops the item. Results sit in an output register, so a
// new item is taken while the last result waits.
// Stored tags keep the low TAG_BITS bits of person_tag (up to 16).
module oldest_first_removal_queue
  import ofrq_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [7:0] age, [23:8] person_tag, rest zero
  input  logic              s_tuser,   // [0] operation
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [7:0] removed_age, [23:8] removed_tag,
                                       // [28:24] occupancy, rest zero
  output logic [1:0]        m_tuser    // [1:0] status
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int TW  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int EW  = AGE_W + TW;

  state_t state;

  logic [CW-1:0]    count;
  logic [AW-1:0]    rsp_idx;    // index of entry whose read data arrives now
  logic [AW-1:0]    best_idx;
  logic [AGE_W-1:0] best_age;
  logic [TW-1:0]    best_tag;
  logic [AW-1:0]    wr_ptr;     // gap position during the shift

  status_t          rsp_status;
  logic [AGE_W-1:0] rsp_age;
  logic [TW-1:0]    rsp_tag;

  // memory port signals
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  logic [AGE_W-1:0] in_age;
  logic [TAG_W-1:0] in_tag;
  logic             accept;
  logic             is_remove;

  logic [AGE_W-1:0] rd_age;
  logic [TW-1:0]    rd_tag;

  logic             take_new;
  logic [AW-1:0]    best_idx_next;
  logic [AGE_W-1:0] best_age_next;
  logic [TW-1:0]    best_tag_next;
  logic             scan_last;
  logic [CW-1:0]    scan_rd;
  logic [CW-1:0]    shift_first;
  logic [CW-1:0]    shift_rd;
  logic             out_free;

  assign in_age    = s_tdata[AGE_W-1:0];
  assign in_tag    = s_tdata[AGE_W +: TAG_W];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_remove = (s_tuser == OP_REMOVE);

  assign rd_age = rd_data[EW-1 -: AGE_W];
  assign rd_tag = rd_data[TW-1:0];

  // running maximum; strict compare keeps the earliest on a tie
  assign take_new      = (rsp_idx == '0) || (rd_age > best_age);
  assign best_idx_next = take_new ? rsp_idx : best_idx;
  assign best_age_next = take_new ? rd_age  : best_age;
  assign best_tag_next = take_new ? rd_tag  : best_tag;

  assign scan_rd     = CW'(rsp_idx) + CW'(1);
  assign scan_last   = (scan_rd == count);
  assign shift_first = CW'(best_idx_next) + CW'(1);
  assign shift_rd    = CW'(wr_ptr) + CW'(2);
  assign out_free    = !m_tvalid || m_tready;

  // Memory port steering. Reads and writes never target the same entry in
  // one cycle: the shift writes slot i while reading slot i + 2.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {in_age, in_tag[TW-1:0]};
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && !is_remove && (count < CW'(CAPACITY))) begin
          wr_en = 1'b1;
        end
        if (accept && is_remove && (count != '0)) begin
          rd_en = 1'b1;
        end
      end
      S_SCAN: begin
        if (!scan_last) begin
          rd_en   = 1'b1;
          rd_addr = scan_rd[AW-1:0];
        end else if (shift_first < count) begin
          rd_en   = 1'b1;
          rd_addr = shift_first[AW-1:0];
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = wr_ptr;
        wr_data = rd_data;
        if (shift_rd < count) begin
          rd_en   = 1'b1;
          rd_addr = shift_rd[AW-1:0];
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  ofrq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp_age <= '0;
            rsp_tag <= '0;
            state   <= S_RESP;
            if (!is_remove) begin
              if (count < CW'(CAPACITY)) begin
                count      <= count + CW'(1);
                rsp_status <= ST_INSERTED;
              end else begin
                rsp_status <= ST_FULL;
              end
            end else if (count == '0) begin
              rsp_status <= ST_EMPTY;
            end else begin
              rsp_idx <= '0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          best_idx <= best_idx_next;
          best_age <= best_age_next;
          best_tag <= best_tag_next;
          rsp_idx  <= rsp_idx + AW'(1);
          if (scan_last) begin
            rsp_status <= ST_REMOVED;
            rsp_age    <= best_age_next;
            rsp_tag    <= best_tag_next;
            if (shift_first < count) begin
              wr_ptr <= best_idx_next;
              state  <= S_SHIFT;
            end else begin
              count <= count - CW'(1);
              state <= S_RESP;
            end
          end
        end
        S_SHIFT: begin
          wr_ptr <= wr_ptr + AW'(1);
          if (!(shift_rd < count)) begin
            count <= count - CW'(1);
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      m_tuser <= rsp_status;
      m_tdata <= {(DATA_W - AGE_W - TAG_W - OCC_W)'(0), OCC_W'(count),
                  TAG_W'(rsp_tag), rsp_age};
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_remove && (count < CW'(CAPACITY))) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the queue");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(rsp_idx) < count))
    else $error("scan beyond held entries");

endmodule
